// File: rtl/slrp_pkg.sv
// ----------------------------------------------------------------------------
// slrp_pkg
// Shared constants, cell data types and the arctangent table of the slerp core.
// ----------------------------------------------------------------------------
package slrp_pkg;

	// number formats and step counts
	localparam int FRAC_BITS       = 14;
	localparam int TRIG_ITERATIONS = 16;
	localparam int STEP_W          = $clog2(TRIG_ITERATIONS);
	localparam int SQRT_STEPS      = 31;
	localparam int DIV_STEPS       = 42;
	localparam int LATENCY         = 3 + SQRT_STEPS + TRIG_ITERATIONS + 1 +
		TRIG_ITERATIONS + DIV_STEPS + 3;

	// square root cell data: partial remainder, root so far, radicand bits left
	typedef struct packed {
		logic [33:0] rem;
		logic [30:0] root;
		logic [61:0] rad;
	} sq_t;

	// cordic cell data, angles in Q30 radians
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
	} cd_t;

	// divider cell data: remainder, quotient so far, dividend bits left, divisor
	typedef struct packed {
		logic [32:0] rem;
		logic [41:0] quo;
		logic [41:0] dvd;
		logic [31:0] den;
	} dv_t;

	// atan(2^-i) in Q30, rounded to nearest
	function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] idx);
		logic [30:0] v;
		case (idx)
			4'd0:    v = 31'd843314857;
			4'd1:    v = 31'd497837829;
			4'd2:    v = 31'd263043837;
			4'd3:    v = 31'd133525159;
			4'd4:    v = 31'd67021687;
			4'd5:    v = 31'd33543516;
			4'd6:    v = 31'd16775851;
			4'd7:    v = 31'd8388437;
			4'd8:    v = 31'd4194283;
			4'd9:    v = 31'd2097149;
			4'd10:   v = 31'd1048576;
			4'd11:   v = 31'd524288;
			4'd12:   v = 31'd262144;
			4'd13:   v = 31'd131072;
			4'd14:   v = 31'd65536;
			4'd15:   v = 31'd32768;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/slrp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// slrp_sqrt_cell
// One digit step of the integer square root: one root bit per cell.
// ----------------------------------------------------------------------------
module slrp_sqrt_cell import slrp_pkg::*; (
	input  logic clk,
	input  sq_t  d_in,
	output sq_t  d_out
);

	logic [33:0] rem_sh;
	logic [33:0] trial;
	sq_t         nxt;
	sq_t         d_q;

	// bring down the next pair and try the next root bit
	always_comb begin
		rem_sh = {d_in.rem[31:0], d_in.rad[61:60]};
		trial  = {1'b0, d_in.root, 2'b01};
		nxt.rad = {d_in.rad[59:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {d_in.root[29:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {d_in.root[29:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign d_out = d_q;

endmodule

// File: rtl/slrp_cordic_cell.sv
// ----------------------------------------------------------------------------
// slrp_cordic_cell
// One cordic micro-rotation, vectoring or rotation by the mode input.
// ----------------------------------------------------------------------------
module slrp_cordic_cell import slrp_pkg::*; (
	input  logic              clk,
	input  logic              vectoring,
	input  logic [STEP_W-1:0] step,
	input  cd_t               d_in,
	output cd_t               d_out
);

	logic signed [33:0] xi;
	logic signed [33:0] yi;
	logic signed [32:0] zi;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [32:0] ang;
	logic               up;
	cd_t                nxt;
	cd_t                d_q;

	// direction from the sign of y (vectoring) or of z (rotation)
	always_comb begin
		xi  = d_in.x;
		yi  = d_in.y;
		zi  = d_in.z;
		dx  = yi >>> step;
		dy  = xi >>> step;
		ang = $signed({2'b00, atan_q30(step)});
		up  = vectoring ? (yi[33] || (yi == '0)) : !zi[32];
		if (up) begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = zi - ang;
		end else begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = zi + ang;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign d_out = d_q;

endmodule

// File: rtl/slrp_div_cell.sv
// ----------------------------------------------------------------------------
// slrp_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module slrp_div_cell import slrp_pkg::*; (
	input  logic clk,
	input  dv_t  d_in,
	output dv_t  d_out
);

	logic [32:0] rem_sh;
	dv_t         nxt;
	dv_t         d_q;

	// shift in the next dividend bit and subtract where it fits
	always_comb begin
		rem_sh  = {d_in.rem[31:0], d_in.dvd[41]};
		nxt.dvd = {d_in.dvd[40:0], 1'b0};
		nxt.den = d_in.den;
		if (rem_sh >= {1'b0, d_in.den}) begin
			nxt.rem = rem_sh - {1'b0, d_in.den};
			nxt.quo = {d_in.quo[40:0], 1'b1};
		end else begin
			nxt.rem = rem_sh;
			nxt.quo = {d_in.quo[40:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign d_out = d_q;

endmodule

// File: rtl/quaternion_slerp_core.sv
// ----------------------------------------------------------------------------
// quaternion_slerp_core
// Fixed-point quaternion slerp built from rows of square root, cordic and
// divider cells, taking one request per clock.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  request   start, busy, first_*, second_*, blend     start & !busy
//  result    done, out_*, degenerate                   done, one cycle
//  config    cfg_valid, cfg_ready, cfg_data            cfg_valid & cfg_ready
//
//  one request per clock; each result passes the input stages, the 31-cell root row,
//  two 16-cell cordic rows, the 42-cell divider and the output stages.
//  busy stays low: the pipeline never stops, as the result side cannot stall.
//  reset clears the valid chain and floor_q; cfg_ready is always high.
// ----------------------------------------------------------------------------
module quaternion_slerp_core import slrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] first_scalar,
	input  logic signed [15:0] first_i,
	input  logic signed [15:0] first_j,
	input  logic signed [15:0] first_k,
	input  logic signed [15:0] second_scalar,
	input  logic signed [15:0] second_i,
	input  logic signed [15:0] second_j,
	input  logic signed [15:0] second_k,
	input  logic        [16:0] blend,
	output logic               done,
	output logic signed [15:0] out_scalar,
	output logic signed [15:0] out_i,
	output logic signed [15:0] out_j,
	output logic signed [15:0] out_k,
	output logic               degenerate,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic         [7:0] cfg_data
);

	localparam logic [16:0] T_ONE     = 17'd65536;
	localparam logic [33:0] DOT_ONE   = 34'd1 << (2 * FRAC_BITS);
	localparam logic [61:0] RAD_ONE   = 62'd1 << 60;
	localparam logic [33:0] X_ONE     = 34'd1 << 30;
	localparam logic [41:0] SCALE_LIM = 42'd1 << 40;
	localparam logic signed [59:0] ROUND_HALF = 60'sd536870912;
	localparam logic signed [59:0] OUT_MAX    = 60'sd32767;
	localparam logic signed [59:0] OUT_MIN    = -60'sd32768;

	typedef struct packed {
		logic [3:0][15:0] p;
		logic [3:0][16:0] qn;
		logic [16:0]      t;
		logic [30:0]      c;
	} sq_sb_t;

	typedef struct packed {
		logic [3:0][15:0] p;
		logic [3:0][16:0] qn;
		logic [16:0]      t;
		logic             degen;
	} vec_sb_t;

	typedef struct packed {
		logic [3:0][15:0] p;
		logic [3:0][16:0] qn;
		logic             degen;
	} rot_sb_t;

	typedef struct packed {
		logic [3:0][15:0] p;
		logic [3:0][16:0] qn;
		logic             degen;
		logic [1:0]       ovf;
		logic [1:0]       neg;
	} div_sb_t;

	logic               accept;
	logic [LATENCY-1:0] vld_q;
	logic [7:0]         floor_q;

	logic [3:0][31:0]   prod_s1;
	logic [3:0][15:0]   p_s1;
	logic [3:0][15:0]   q_s1;
	logic [16:0]        t_s1;

	logic [3:0][15:0]   p_s2;
	logic [3:0][16:0]   qn_s2;
	logic [16:0]        t_s2;
	logic [30:0]        c_s2;

	logic [60:0]        rad_s3;
	logic [3:0][15:0]   p_s3;
	logic [3:0][16:0]   qn_s3;
	logic [16:0]        t_s3;
	logic [30:0]        c_s3;

	logic [30:0]        theta_s5;
	logic [30:0]        a1_s5;
	logic [30:0]        a2_s5;
	logic [3:0][15:0]   p_s5;
	logic [3:0][16:0]   qn_s5;
	logic               degen_s5;

	logic signed [41:0] scale1_s7;
	logic signed [41:0] scale2_s7;
	logic [3:0][15:0]   p_s7;
	logic [3:0][16:0]   qn_s7;
	logic               degen_s7;

	logic signed [57:0] pa_s8 [4];
	logic signed [58:0] pb_s8 [4];
	logic [3:0][15:0]   p_s8;
	logic               degen_s8;

	logic signed [15:0] res_q [4];
	logic               degen_q;

	logic signed [33:0] dot;
	logic               dot_neg;
	logic [33:0]        dot_abs;
	logic [33:0]        dot_clamp;
	logic [61:0]        cc;
	logic [30:0]        theta;
	logic [47:0]        m1;
	logic [47:0]        m2;

	sq_t     sq_d   [SQRT_STEPS+1];
	cd_t     vec_d  [TRIG_ITERATIONS+1];
	cd_t     rot_d  [3][TRIG_ITERATIONS+1];
	dv_t     div_d  [2][DIV_STEPS+1];
	sq_sb_t  sq_sb_q  [SQRT_STEPS];
	vec_sb_t vec_sb_q [TRIG_ITERATIONS];
	rot_sb_t rot_sb_q [TRIG_ITERATIONS];
	div_sb_t div_sb_q [DIV_STEPS];

	logic signed [33:0] sc;
	logic               degen_rot;
	logic [33:0]        num_abs [2];
	logic               num_neg [2];
	logic               num_ovf [2];
	logic [41:0]        mag     [2];
	logic signed [59:0] acc     [4];
	logic signed [59:0] rnd     [4];

	assign accept    = start && !busy;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// valid chain and the floor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			floor_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], accept};
			if (cfg_valid && cfg_ready) begin
				floor_q <= cfg_data;
			end
		end
	end

	// stage 1: component products, blend clamped to one
	always_ff @(posedge clk) begin
		prod_s1[0] <= first_scalar * second_scalar;
		prod_s1[1] <= first_i * second_i;
		prod_s1[2] <= first_j * second_j;
		prod_s1[3] <= first_k * second_k;
		p_s1 <= {first_k, first_j, first_i, first_scalar};
		q_s1 <= {second_k, second_j, second_i, second_scalar};
		t_s1 <= (blend > T_ONE) ? T_ONE : blend;
	end

	// stage 2: dot product, shortest arc, clamp to one and move to Q30
	always_comb begin
		dot = 34'($signed(prod_s1[0])) + 34'($signed(prod_s1[1])) +
			34'($signed(prod_s1[2])) + 34'($signed(prod_s1[3]));
		dot_neg   = dot[33];
		dot_abs   = dot_neg ? 34'(-dot) : 34'(dot);
		dot_clamp = (dot_abs > DOT_ONE) ? DOT_ONE : dot_abs;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			qn_s2[i] <= dot_neg ? 17'(-17'($signed(q_s1[i]))) : 17'($signed(q_s1[i]));
		end
		p_s2 <= p_s1;
		t_s2 <= t_s1;
		c_s2 <= {dot_clamp[28:0], 2'b00};
	end

	// stage 3: radicand one minus c squared
	assign cc = c_s2 * c_s2;

	always_ff @(posedge clk) begin
		rad_s3 <= 61'(RAD_ONE - cc);
		p_s3   <= p_s2;
		qn_s3  <= qn_s2;
		t_s3   <= t_s2;
		c_s3   <= c_s2;
	end

	// square root row
	assign sq_d[0] = '{rem: '0, root: '0, rad: {1'b0, rad_s3}};

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		slrp_sqrt_cell u_cell (.clk(clk), .d_in(sq_d[g]), .d_out(sq_d[g+1]));
	end

	always_ff @(posedge clk) begin
		sq_sb_q[0] <= '{p: p_s3, qn: qn_s3, t: t_s3, c: c_s3};
		for (int i = 1; i < SQRT_STEPS; i++) begin
			sq_sb_q[i] <= sq_sb_q[i-1];
		end
	end

	// vectoring row: theta = atan2(s, c)
	assign vec_d[0] = '{x: $signed({3'b000, sq_sb_q[SQRT_STEPS-1].c}),
		y: $signed({3'b000, sq_d[SQRT_STEPS].root}), z: '0};

	for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_vec
		slrp_cordic_cell u_cell (
			.clk       (clk),
			.vectoring (1'b1),
			.step      (STEP_W'(g)),
			.d_in      (vec_d[g]),
			.d_out     (vec_d[g+1])
		);
	end

	always_ff @(posedge clk) begin
		vec_sb_q[0] <= '{p: sq_sb_q[SQRT_STEPS-1].p, qn: sq_sb_q[SQRT_STEPS-1].qn,
			t: sq_sb_q[SQRT_STEPS-1].t,
			degen: ((sq_d[SQRT_STEPS].root >> (30 - FRAC_BITS)) <= 31'(floor_q))};
		for (int i = 1; i < TRIG_ITERATIONS; i++) begin
			vec_sb_q[i] <= vec_sb_q[i-1];
		end
	end

	// stage 5: theta floored at zero and the two blended angles
	always_comb begin
		theta = vec_d[TRIG_ITERATIONS].z[32] ? '0 : vec_d[TRIG_ITERATIONS].z[30:0];
		m1 = theta * (T_ONE - vec_sb_q[TRIG_ITERATIONS-1].t);
		m2 = theta * vec_sb_q[TRIG_ITERATIONS-1].t;
	end

	always_ff @(posedge clk) begin
		theta_s5 <= theta;
		a1_s5    <= m1[46:16];
		a2_s5    <= m2[46:16];
		p_s5     <= vec_sb_q[TRIG_ITERATIONS-1].p;
		qn_s5    <= vec_sb_q[TRIG_ITERATIONS-1].qn;
		degen_s5 <= vec_sb_q[TRIG_ITERATIONS-1].degen;
	end

	// rotation rows: sin(theta) and the two blended sines
	assign rot_d[0][0] = '{x: $signed(X_ONE), y: '0, z: $signed({2'b00, theta_s5})};
	assign rot_d[1][0] = '{x: $signed(X_ONE), y: '0, z: $signed({2'b00, a1_s5})};
	assign rot_d[2][0] = '{x: $signed(X_ONE), y: '0, z: $signed({2'b00, a2_s5})};

	for (genvar l = 0; l < 3; l++) begin : g_rot_lane
		for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_rot
			slrp_cordic_cell u_cell (
				.clk       (clk),
				.vectoring (1'b0),
				.step      (STEP_W'(g)),
				.d_in      (rot_d[l][g]),
				.d_out     (rot_d[l][g+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		rot_sb_q[0] <= '{p: p_s5, qn: qn_s5, degen: degen_s5};
		for (int i = 1; i < TRIG_ITERATIONS; i++) begin
			rot_sb_q[i] <= rot_sb_q[i-1];
		end
	end

	// divider set-up: magnitudes, signs and quotient overflow
	always_comb begin
		sc        = rot_d[0][TRIG_ITERATIONS].y;
		degen_rot = rot_sb_q[TRIG_ITERATIONS-1].degen || sc[33] || (sc == '0);
		for (int l = 0; l < 2; l++) begin
			num_neg[l] = rot_d[l+1][TRIG_ITERATIONS].y[33];
			num_abs[l] = num_neg[l] ? 34'(-rot_d[l+1][TRIG_ITERATIONS].y)
				: 34'(rot_d[l+1][TRIG_ITERATIONS].y);
			num_ovf[l] = {12'b0, num_abs[l][31:12]} >= sc[31:0];
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_div_lane
		assign div_d[l][0] = '{rem: {13'b0, num_abs[l][31:12]}, quo: '0,
			dvd: {num_abs[l][11:0], 30'b0}, den: sc[31:0]};
		for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
			slrp_div_cell u_cell (.clk(clk), .d_in(div_d[l][g]), .d_out(div_d[l][g+1]));
		end
	end

	always_ff @(posedge clk) begin
		div_sb_q[0] <= '{p: rot_sb_q[TRIG_ITERATIONS-1].p,
			qn: rot_sb_q[TRIG_ITERATIONS-1].qn, degen: degen_rot,
			ovf: {num_ovf[1], num_ovf[0]}, neg: {num_neg[1], num_neg[0]}};
		for (int i = 1; i < DIV_STEPS; i++) begin
			div_sb_q[i] <= div_sb_q[i-1];
		end
	end

	// stage 7: clamp quotients and restore sign
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag[l] = (div_sb_q[DIV_STEPS-1].ovf[l] ||
				(div_d[l][DIV_STEPS].quo > SCALE_LIM)) ? SCALE_LIM
				: div_d[l][DIV_STEPS].quo;
		end
	end

	always_ff @(posedge clk) begin
		scale1_s7 <= div_sb_q[DIV_STEPS-1].neg[0] ? -$signed(mag[0]) : $signed(mag[0]);
		scale2_s7 <= div_sb_q[DIV_STEPS-1].neg[1] ? -$signed(mag[1]) : $signed(mag[1]);
		p_s7      <= div_sb_q[DIV_STEPS-1].p;
		qn_s7     <= div_sb_q[DIV_STEPS-1].qn;
		degen_s7  <= div_sb_q[DIV_STEPS-1].degen;
	end

	// stage 8: weighted components
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			pa_s8[i] <= scale1_s7 * $signed(p_s7[i]);
			pb_s8[i] <= scale2_s7 * $signed(qn_s7[i]);
		end
		p_s8     <= p_s7;
		degen_s8 <= degen_s7;
	end

	// output stage: round, saturate, or pass the first quaternion
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			acc[i] = 60'(pa_s8[i]) + 60'(pb_s8[i]) + ROUND_HALF;
			rnd[i] = acc[i] >>> 30;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (degen_s8) begin
				res_q[i] <= $signed(p_s8[i]);
			end else if (rnd[i] > OUT_MAX) begin
				res_q[i] <= 16'sd32767;
			end else if (rnd[i] < OUT_MIN) begin
				res_q[i] <= -16'sd32768;
			end else begin
				res_q[i] <= rnd[i][15:0];
			end
		end
		degen_q <= degen_s8;
	end

	assign done       = vld_q[LATENCY-1];
	assign out_scalar = res_q[0];
	assign out_i      = res_q[1];
	assign out_j      = res_q[2];
	assign out_k      = res_q[3];
	assign degenerate = degen_q;

endmodule

// File: rtl/slrp_checker.sv
// ----------------------------------------------------------------------------
// slrp_checker
// Port-level checks on request to result timing and the degenerate pass-through.
// ----------------------------------------------------------------------------
module slrp_checker import slrp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic signed [15:0] first_scalar,
	input logic signed [15:0] first_i,
	input logic signed [15:0] first_j,
	input logic signed [15:0] first_k,
	input logic               done,
	input logic signed [15:0] out_scalar,
	input logic signed [15:0] out_i,
	input logic signed [15:0] out_j,
	input logic signed [15:0] out_k,
	input logic               degenerate
);

	// every accepted request gives a result after the fixed latency
	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after request");

	// no result without a request the fixed latency earlier
	a_result_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without request");

	// degenerate result carries the first quaternion unchanged
	a_degen_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |->
		(out_scalar == $past(first_scalar, LATENCY)) && (out_i == $past(first_i, LATENCY)) &&
		(out_j == $past(first_j, LATENCY)) && (out_k == $past(first_k, LATENCY)))
		else $error("degenerate result differs from first quaternion");

endmodule

bind quaternion_slerp_core slrp_checker u_slrp_checker (.*);

// File: tb/slerp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slerp_result_checker
// Watches the request, result and config channels of the slerp core, predicts
// each interpolated quaternion and compares it field by field in order.
// ----------------------------------------------------------------------------
module slerp_result_checker import slrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] first_scalar,
	input  logic signed [15:0] first_i,
	input  logic signed [15:0] first_j,
	input  logic signed [15:0] first_k,
	input  logic signed [15:0] second_scalar,
	input  logic signed [15:0] second_i,
	input  logic signed [15:0] second_j,
	input  logic signed [15:0] second_k,
	input  logic        [16:0] blend,
	input  logic               done,
	input  logic signed [15:0] out_scalar,
	input  logic signed [15:0] out_i,
	input  logic signed [15:0] out_j,
	input  logic signed [15:0] out_k,
	input  logic               degenerate,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic         [7:0] cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 result_count,
	output int                 degen_count
);

	typedef struct packed {
		logic signed [15:0] s, i, j, k;
		logic               degen;
	} quat_res_t;

	quat_res_t    interp_q[$];
	logic   [7:0] floor_reg;
	longint       atan_tab[TRIG_ITERATIONS];

	// atan(1/n) in Q60 by its alternating series
	function automatic longint atan_inv(longint unsigned n);
		longint unsigned p, nn, k;
		longint          sum;
		bit              neg;
		p   = (64'd1 << 60) / n;
		nn  = n * n;
		k   = 1;
		sum = 0;
		neg = 0;
		while (p != 0) begin
			sum = neg ? sum - longint'(p / k) : sum + longint'(p / k);
			neg = !neg;
			k  += 2;
			p   = p / nn;
		end
		return sum;
	endfunction

	initial begin
		longint v;
		for (int n = 0; n < TRIG_ITERATIONS; n++) begin
			if (n == 0)
				v = 4 * atan_inv(5) - atan_inv(239);
			else
				v = atan_inv(64'd1 << n);
			atan_tab[n] = (v + (64'sd1 << 29)) >>> 30;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r  = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// cordic vectoring: angle of (x, y)
	function automatic longint vec_angle(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		for (int n = 0; n < TRIG_ITERATIONS; n++) begin
			dx = y >>> n;
			dy = x >>> n;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_tab[n];
			end else begin
				x -= dx; y += dy; z -= atan_tab[n];
			end
		end
		return z;
	endfunction

	// cordic rotation from (2^30, 0), gain left in
	function automatic longint rot_sine(longint z);
		longint x, y, dx, dy;
		x = 64'sd1 << 30;
		y = 0;
		for (int n = 0; n < TRIG_ITERATIONS; n++) begin
			dx = y >>> n;
			dy = x >>> n;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[n];
			end else begin
				x += dx; y -= dy; z += atan_tab[n];
			end
		end
		return y;
	endfunction

	function automatic longint weight(longint num, longint den);
		longint w;
		w = (num * (64'sd1 << 30)) / den;
		if (w > (64'sd1 << 40))  w = 64'sd1 << 40;
		if (w < -(64'sd1 << 40)) w = -(64'sd1 << 40);
		return w;
	endfunction

	function automatic quat_res_t slerp_predict(longint p[4], longint q[4],
		longint unsigned t, logic [7:0] flr);
		quat_res_t res;
		longint    dot, c, s, theta, sth, w1, w2, r;
		logic      dg;
		dot = 0;
		for (int n = 0; n < 4; n++)
			dot += p[n] * q[n];
		if (t > 65536)
			t = 65536;
		// shortest arc
		if (dot < 0) begin
			dot = -dot;
			for (int n = 0; n < 4; n++)
				q[n] = -q[n];
		end
		if (dot > (64'sd1 << (2 * FRAC_BITS)))
			dot = 64'sd1 << (2 * FRAC_BITS);
		c     = dot << (30 - 2 * FRAC_BITS);
		s     = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
		dg    = (longint'(s >> (30 - FRAC_BITS)) <= longint'(flr));
		theta = 0;
		sth   = 0;
		if (!dg) begin
			theta = vec_angle(c, s);
			if (theta < 0)
				theta = 0;
			sth = rot_sine(theta);
			if (sth <= 0)
				dg = 1;
		end
		res.degen = dg;
		if (dg) begin
			res.s = p[0]; res.i = p[1]; res.j = p[2]; res.k = p[3];
			return res;
		end
		w1 = weight(rot_sine((theta * longint'(65536 - t)) >>> 16), sth);
		w2 = weight(rot_sine((theta * longint'(t)) >>> 16), sth);
		for (int n = 0; n < 4; n++) begin
			r = (w1 * p[n] + w2 * q[n] + (64'sd1 << 29)) >>> 30;
			if (r > 32767)  r = 32767;
			if (r < -32768) r = -32768;
			case (n)
				0: res.s = r[15:0];
				1: res.i = r[15:0];
				2: res.j = r[15:0];
				default: res.k = r[15:0];
			endcase
		end
		return res;
	endfunction

	assign pending = interp_q.size();

	// watch channels, predict on requests, compare on results
	always @(posedge clk or negedge arst_n) begin
		longint    p[4], q[4];
		quat_res_t want, got;
		if (!arst_n) begin
			floor_reg    <= '0;
			fail_count   <= 0;
			result_count <= 0;
			degen_count  <= 0;
			interp_q.delete();
		end else begin
			if (done) begin
				got = '{out_scalar, out_i, out_j, out_k, degenerate};
				result_count <= result_count + 1;
				if (degenerate)
					degen_count <= degen_count + 1;
				if (interp_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result %p", $realtime, got);
					fail_count <= fail_count + 1;
				end else begin
					want = interp_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp %p got %p", $realtime, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				p = '{first_scalar, first_i, first_j, first_k};
				q = '{second_scalar, second_i, second_j, second_k};
				interp_q.push_back(slerp_predict(p, q, blend, floor_reg));
			end
			if (cfg_valid && cfg_ready)
				floor_reg <= cfg_data;
		end
	end

endmodule

// File: tb/tb_quaternion_slerp_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_slerp_core
// Drives directed and random quaternion pairs through the slerp core under
// several sine floor settings and sender idle rates; the checker judges results.
// ----------------------------------------------------------------------------
module tb_quaternion_slerp_core;
	import slrp_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic               clk, arst_n, start, busy, done, degenerate;
	logic               cfg_valid, cfg_ready;
	logic         [7:0] cfg_data;
	logic signed [15:0] first_scalar, first_i, first_j, first_k;
	logic signed [15:0] second_scalar, second_i, second_j, second_k;
	logic signed [15:0] out_scalar, out_i, out_j, out_k;
	logic        [16:0] blend;
	int                 fail_count, pending, result_count, degen_count;
	int                 idle_pct, sent, quiet;

	quaternion_slerp_core dut (.*);
	slerp_result_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// send one request, then idle at random
	task automatic send_pair(input logic [15:0] a0, a1, a2, a3, b0, b1, b2, b3,
		input logic [16:0] t);
		@(negedge clk);
		{first_scalar, first_i, first_j, first_k}     = {a0, a1, a2, a3};
		{second_scalar, second_i, second_j, second_k} = {b0, b1, b2, b3};
		blend = t;
		start = 1;
		do @(posedge clk); while (busy);
		sent++;
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 0;
			repeat ($urandom_range(6)) @(negedge clk);
		end
	endtask

	task automatic write_floor(input logic [7:0] v);
		@(negedge clk);
		start = 0;
		while (pending != 0) @(negedge clk);
		cfg_valid = 1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// unit quaternion, optionally near a given one
	task automatic rand_unit(output logic [15:0] r[4], input real base[4], input real spread);
		real v[4], m;
		m = 0;
		for (int n = 0; n < 4; n++) begin
			v[n] = base[n] + spread * (real'($urandom_range(20000)) / 10000.0 - 1.0);
			m += v[n] * v[n];
		end
		if (m < 1e-9) begin
			v[0] = 1.0;
			m    = 1.0;
		end
		m = $sqrt(m);
		for (int n = 0; n < 4; n++)
			r[n] = 16'($rtoi(v[n] / m * 16384.0));
	endtask

	task automatic random_phase(input int count);
		logic [15:0] a[4], b[4];
		real         ra[4], zero[4];
		logic [16:0] t;
		zero = '{0.0, 0.0, 0.0, 0.0};
		repeat (count) begin
			t = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
			case ($urandom_range(9))
				0, 1: begin
					// raw bits, non-unit inputs
					for (int n = 0; n < 4; n++) begin
						a[n] = 16'($urandom);
						b[n] = 16'($urandom);
					end
				end
				2, 3: begin
					// nearby pair, small angles around the floor
					rand_unit(a, zero, 1.0);
					for (int n = 0; n < 4; n++)
						ra[n] = $itor($signed(a[n])) / 16384.0;
					rand_unit(b, ra, 0.002 * $urandom_range(1, 20));
				end
				default: begin
					rand_unit(a, zero, 1.0);
					rand_unit(b, zero, 1.0);
				end
			endcase
			send_pair(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3], t);
		end
	endtask

	// stall watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 0; start = 0; cfg_valid = 0; cfg_data = '0; blend = '0;
		{first_scalar, first_i, first_j, first_k}     = '0;
		{second_scalar, second_i, second_j, second_k} = '0;
		sent = 0; idle_pct = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset floor, no idling
		send_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 32768);
		send_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 0);
		send_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 65536);
		send_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 17'h1FFFF);
		send_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 65537);
		send_pair(16384, 0, 0, 0, -16384, 0, 0, 0, 20000);
		send_pair(11585, 11585, 0, 0, -11585, 0, 11585, 0, 40000);
		send_pair(16'h8000, 0, 0, 0, 16384, 0, 0, 0, 30000);
		send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16384, 0, 0, 0, 10000);
		send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 50000);
		send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 50000);
		send_pair(16384, 0, 0, 0, 16383, 181, 0, 0, 32768);
		send_pair(16384, 0, 0, 0, 16384, 40, 0, 0, 32768);
		send_pair(0, 0, 0, 0, 0, 0, 0, 0, 65536);
		send_pair(100, -200, 300, -400, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 123);
		send_pair(11585, 0, 11585, 0, 0, 11585, 0, 11585, 1);
		random_phase(200);

		// largest floor, sender mostly idle
		write_floor(8'hFF);
		idle_pct = 82;
		send_pair(16384, 0, 0, 0, 16300, 1600, 0, 0, 32768);
		send_pair(16384, 0, 0, 0, 16000, 3500, 0, 0, 32768);
		random_phase(300);

		// mid floor, no idling
		write_floor(8'($urandom_range(2, 254)));
		idle_pct = 0;
		random_phase(400);

		// floor of one, light idling
		write_floor(8'd1);
		idle_pct = 7;
		random_phase(400);

		@(negedge clk);
		start = 0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		$display("covered %0d requests over floors 0, 255, mid and 1 with idle rates 0/82/7%%",
			sent);
		$display("%0d results checked, %0d of them degenerate", result_count, degen_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
